@@ src/lfr_pkg.sv @@
// Shared types and constants for the LRU frame replacer.
`default_nettype none
package lfr_pkg;

	// Default number of frames, and so of cells in the order row.
	localparam int NUM_FRAMES_DEF = 64;

	// Field widths.
	localparam int MODE_W  = 2;
	localparam int FRAME_W = 6;
	localparam int COUNT_W = 7;

	// Capacity after reset.
	localparam logic [COUNT_W-1:0] CAPACITY_RST = COUNT_W'(64);

	// Request operation codes.
	localparam logic [MODE_W-1:0] MODE_VICTIM = 2'd0;
	localparam logic [MODE_W-1:0] MODE_PIN    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_UNPIN  = 2'd2;

	// Contents of one cell, as seen by its neighbors.
	typedef struct packed {
		logic               valid;
		logic [FRAME_W-1:0] frame;
	} lfr_link_t;

	// Command broadcast to every cell for the current request.
	typedef struct packed {
		logic               step;   // a request is accepted this cycle
		logic               victim; // pop the oldest entry
		logic               pin;    // remove the entry that matches key
		logic               load;   // append key after the newest entry
		logic [FRAME_W-1:0] key;
	} lfr_cmd_t;

endpackage
`default_nettype wire

@@ src/lfr_if.sv @@
// Request and response channel interfaces of the LRU frame replacer.
`default_nettype none

// Request channel: one operation per beat.
interface lfr_req_if import lfr_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [MODE_W-1:0]  mode;
	logic [FRAME_W-1:0] frame;

	modport source (output valid, output mode, output frame, input ready);
	modport sink (input valid, input mode, input frame, output ready);
endinterface

// Response channel: one result per beat.
interface lfr_rsp_if import lfr_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               found;
	logic [FRAME_W-1:0] evict_frame;
	logic [COUNT_W-1:0] count;

	modport source (output valid, output found, output evict_frame, output count,
		input ready);
	modport sink (input valid, input found, input evict_frame, input count,
		output ready);
endinterface

`default_nettype wire

@@ src/lfr_cell.sv @@
// One cell of the order row: holds one listed frame and shifts toward the oldest end.
`default_nettype none
module lfr_cell import lfr_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire lfr_cmd_t  cmd,
	input  wire logic      left_valid, // older neighbor holds an entry
	input  wire lfr_link_t right,      // newer neighbor's contents
	input  wire logic      any_in,     // a match exists in an older cell
	output logic           any_out,    // a match exists here or in an older cell
	output lfr_link_t      own
);

	logic               valid_q;
	logic [FRAME_W-1:0] frame_q;
	logic               match;
	logic               shift;
	logic               fill;

	// Compare against the key and pass the match on toward the newer end.
	assign match   = valid_q && (frame_q == cmd.key);
	assign any_out = any_in | match;

	// Shift when popping, or when a removed entry lies here or further back.
	assign shift = cmd.victim | (cmd.pin & any_out);
	// The first empty cell takes an appended frame.
	assign fill  = cmd.load & ~valid_q & left_valid;

	// Occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.step) begin
			if (shift) begin
				valid_q <= right.valid;
			end else if (fill) begin
				valid_q <= 1'b1;
			end
		end
	end

	// Stored frame number.
	always_ff @(posedge clk) begin
		if (cmd.step) begin
			if (shift) begin
				frame_q <= right.frame;
			end else if (fill) begin
				frame_q <= cmd.key;
			end
		end
	end

	assign own.valid = valid_q;
	assign own.frame = frame_q;

endmodule
`default_nettype wire

@@ src/lru_frame_replacer.sv @@
// Top level of the LRU frame replacer: cell row, count, capacity and result register.
//
//  channel   dir  signals                           meaning
//  req       in   valid ready mode frame            victim, pin or unpin request
//  rsp       out  valid ready found evict_frame     one result per request
//                 count
//  cfg       in   cfg_wr_en cfg_wr_data             capacity register write
//
// For each accepted request, every cell of the row compares, shifts or
// fills in the same edge, and the result lands in the output register.
// One request per cycle is sustained while rsp is taken; req stalls only while
// a result waits in the output register and rsp.ready is low.
// Reset empties the row and the count at once and sets capacity to 64.
`default_nettype none
module lru_frame_replacer import lfr_pkg::*; #(
	parameter int NUM_FRAMES = NUM_FRAMES_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	lfr_req_if.sink                 req,
	lfr_rsp_if.source               rsp,
	input  wire logic               cfg_wr_en,
	input  wire logic [COUNT_W-1:0] cfg_wr_data
);

	logic [COUNT_W-1:0] capacity_q;
	logic [COUNT_W-1:0] count_q;
	logic               rsp_valid_q;
	logic               found_q;
	logic [FRAME_W-1:0] evict_frame_q;
	logic [COUNT_W-1:0] rsp_count_q;

	lfr_cmd_t           cmd;
	lfr_link_t          link [NUM_FRAMES];
	logic [NUM_FRAMES:0] any_c;
	logic               step;
	logic               in_range;
	logic               hit;
	logic               is_victim;
	logic               is_pin;
	logic               is_unpin;
	logic               pop;
	logic               drop;
	logic [COUNT_W-1:0] count_d;

	// Handshake: take a request whenever the output register is free or draining.
	assign req.ready = ~rsp_valid_q | rsp.ready;
	assign step      = req.valid & req.ready;

	// Decode the operation.
	always_comb begin
		is_victim = 1'b0;
		is_pin    = 1'b0;
		is_unpin  = 1'b0;
		case (req.mode)
			MODE_VICTIM: is_victim = 1'b1;
			MODE_PIN:    is_pin    = 1'b1;
			MODE_UNPIN:  is_unpin  = 1'b1;
			default:     ;
		endcase
	end

	assign in_range = int'(req.frame) < NUM_FRAMES;
	assign hit      = any_c[NUM_FRAMES];
	assign pop      = is_victim & link[0].valid;
	assign drop     = is_pin & in_range & hit;

	// Command to the row.
	assign cmd.step   = step;
	assign cmd.victim = is_victim;
	assign cmd.pin    = is_pin & in_range;
	assign cmd.load   = is_unpin & in_range & ~hit & (count_q < capacity_q);
	assign cmd.key    = req.frame;

	// Row of cells, oldest entry in cell 0.
	assign any_c[0] = 1'b0;
	for (genvar i = 0; i < NUM_FRAMES; i++) begin : g_cell
		lfr_link_t right_l;
		logic      left_v;
		if (i == NUM_FRAMES - 1) begin : g_last
			assign right_l = '0;
		end else begin : g_mid
			assign right_l = link[i+1];
		end
		if (i == 0) begin : g_first
			assign left_v = 1'b1;
		end else begin : g_rest
			assign left_v = link[i-1].valid;
		end
		lfr_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.left_valid (left_v),
			.right      (right_l),
			.any_in     (any_c[i]),
			.any_out    (any_c[i+1]),
			.own        (link[i])
		);
	end

	// Next entry count.
	always_comb begin
		count_d = count_q;
		if (pop || drop) begin
			count_d = count_q - COUNT_W'(1);
		end else if (cmd.load) begin
			count_d = count_q + COUNT_W'(1);
		end
	end

	// Capacity register and entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAPACITY_RST;
			count_q    <= '0;
		end else begin
			if (cfg_wr_en) begin
				capacity_q <= cfg_wr_data;
			end
			if (step) begin
				count_q <= count_d;
			end
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (step) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (step) begin
			found_q       <= pop;
			evict_frame_q <= pop ? link[0].frame : '0;
			rsp_count_q   <= count_d;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.found       = found_q;
	assign rsp.evict_frame = evict_frame_q;
	assign rsp.count       = rsp_count_q;

endmodule
`default_nettype wire
